### design/bpa_pkg.sv
// Shared constants and types for the buddy page allocator.
package bpa_pkg;

  localparam int MAX_PAGES_DEF  = 1024;
  localparam int MAX_ORDERS_DEF = 11;
  localparam int TOTAL_RST      = 1024;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic [1:0] RC_DONE   = 2'd0;
  localparam logic [1:0] RC_REJECT = 2'd1;
  localparam logic [1:0] RC_NOBLK  = 2'd2;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LAY, S_AORD, S_ASRCH, S_SPLIT,
    S_FCHK, S_FLOOP, S_FBUD, S_FMA, S_FMB, S_FEND, S_FDONE,
    S_PUSH1, S_PUSH2, S_UNL0, S_UNL1, S_OUT
  } state_t;

endpackage

### design/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/buddy_page_allocator_core.sv
// Buddy page allocator: sequencer around status and free-list link memories.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in_     | request   | in_valid / in_ready    | in_command, in_page_count, in_page_index
//  out_    | result    | out_valid / out_ready  | out_result_code, out_block_index,
//          |           |                        | out_free_count
//  APB     | config    | psel/penable/pwrite    | paddr, pwdata, prdata (total_pages)
//
// One request at a time. Allocate runs the order search, an unlink and a split
// per level; free runs the status check, then a buddy test and merge per level;
// a push runs S_PUSH1 then S_PUSH2 and an unlink S_UNL0 then S_UNL1, set by the
// registered read and single write port of each link memory.
// Initialise sweeps all MAX_PAGES entries of the status memory, then lays out blocks.
// Reset: the same status sweep runs after reset; in_ready stays low meanwhile.
// A finished result waits in the output register; the next request is taken
// once the sequencer is back in idle.
module buddy_page_allocator_core #(
  parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
  parameter int MAX_ORDERS = bpa_pkg::MAX_ORDERS_DEF,
  localparam int PW = $clog2(MAX_PAGES),
  localparam int CW = PW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_command,
  input  logic [CW-1:0] in_page_count,
  input  logic [PW-1:0] in_page_index,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_result_code,
  output logic [PW-1:0] out_block_index,
  output logic [CW-1:0] out_free_count,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int LW   = $clog2(MAX_ORDERS);
  localparam int OMX  = (PW > MAX_ORDERS) ? PW : MAX_ORDERS;
  localparam int OW   = $clog2(OMX + 2);
  localparam int SW   = $clog2(MAX_ORDERS + 1) + 1;
  localparam int XW   = CW + 1;
  localparam logic [CW-1:0] NO_PAGE = CW'(MAX_PAGES);

  bpa_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [CW-1:0] total_r;
  logic [CW-1:0] head_r [MAX_ORDERS];
  logic [CW-1:0] head_nxt [MAX_ORDERS];
  logic [CW-1:0] free_r, free_nxt, managed_r, managed_nxt;
  logic [OW-1:0] ocnt_r, ocnt_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, sz_r, sz_nxt, handle_r, handle_nxt;
  logic [OW-1:0] g_r, g_nxt, ord_r, ord_nxt, orig_r, orig_nxt;
  logic [PW-1:0] pg_r, pg_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [OW-1:0] push_ord_r, push_ord_nxt, unl_ord_r, unl_ord_nxt;
  logic [PW-1:0] push_pg_r, push_pg_nxt, unl_pg_r, unl_pg_nxt;
  logic [CW-1:0] push_h_r, push_h_nxt;
  logic [1:0]    code_r, code_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic          out_valid_r;
  logic [1:0]    out_code_r;
  logic [PW-1:0] out_idx_r;
  logic [CW-1:0] out_free_r;

  // memory ports
  logic          st_we, nx_we, pv_we;
  logic [PW-1:0] st_waddr, nx_waddr, pv_waddr, st_raddr;
  logic [SW-1:0] st_wdata, st_rdata;
  logic [CW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

  bpa_ram #(.WIDTH(SW), .DEPTH(MAX_PAGES)) u_status (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(st_raddr), .rdata(st_rdata)
  );
  bpa_ram #(.WIDTH(CW), .DEPTH(MAX_PAGES)) u_next (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata), .raddr(unl_pg_r), .rdata(nx_rdata)
  );
  bpa_ram #(.WIDTH(CW), .DEPTH(MAX_PAGES)) u_prev (
    .clk, .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata), .raddr(unl_pg_r), .rdata(pv_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = 32'(total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= CW'(bpa_pkg::TOTAL_RST);
    end else if (psel && penable && pwrite) begin
      total_r <= pwdata[CW-1:0];
    end
  end

  // shared decisions
  logic          in_fire, out_slot, clr_last;
  logic          init_bad, alloc_bad, free_bad;
  logic [OW-1:0] msb_c, ocnt_init;
  logic [CW-1:0] cur_head, lay_sz;
  logic          head_empty, lay_full, lay_fit;
  logic          srch_out, split_more, fchk_ok;
  logic [XW-1:0] bs_x, pg_x;
  logic [PW-1:0] bs_p, upper;
  logic          aligned, floop_go, bud_ok;
  logic [OW-1:0] st_mag;
  logic [SW-1:0] neg_g1;

  assign in_ready  = (state_r == bpa_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_slot  = !out_valid_r || out_ready;
  assign clr_last  = (clr_r == PW'(MAX_PAGES - 1));
  assign init_bad  = (total_r == '0) || (total_r > NO_PAGE);
  assign alloc_bad = (in_page_count == '0) || (in_page_count > free_r);
  assign free_bad  = ({1'b0, in_page_index} >= managed_r);

  always_comb begin
    msb_c = '0;
    for (int i = 0; i < CW; i++) begin
      if (total_r[i]) begin
        msb_c = OW'(i);
      end
    end
  end
  assign ocnt_init = (msb_c >= OW'(MAX_ORDERS - 1)) ? OW'(MAX_ORDERS) : msb_c + OW'(1);

  assign cur_head   = head_r[g_r[LW-1:0]];
  assign head_empty = (cur_head >= NO_PAGE);
  assign lay_sz     = CW'(1) << g_r;
  assign lay_full   = (free_r == managed_r);
  assign lay_fit    = ((managed_r - free_r) >= lay_sz);
  assign srch_out   = (g_r >= ocnt_r);
  assign split_more = (g_r > ord_r);
  assign upper      = pg_r + PW'(CW'(1) << (g_r - OW'(1)));

  assign st_mag  = OW'(st_rdata[SW-2:0]);
  assign fchk_ok = !st_rdata[SW-1] && (st_rdata != '0) && (st_mag <= ocnt_r);

  assign bs_x    = XW'(1) << g_r;
  assign bs_p    = bs_x[PW-1:0];
  assign pg_x    = XW'(pg_r);
  assign aligned = ((pg_x & ((bs_x << 1) - XW'(1))) == '0);
  assign floop_go = ((g_r + OW'(1)) < ocnt_r) &&
                    (aligned ? ((pg_x + bs_x + bs_x) <= XW'(managed_r)) : (pg_x >= bs_x));
  assign neg_g1  = SW'(0) - SW'(g_r) - SW'(1);
  assign bud_ok  = (st_rdata == neg_g1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpa_pkg::S_CLR:   if (clr_last) state_nxt = ret_r;
      bpa_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_command)
            bpa_pkg::CMD_INIT:  state_nxt = init_bad ? bpa_pkg::S_OUT : bpa_pkg::S_CLR;
            bpa_pkg::CMD_ALLOC: state_nxt = alloc_bad ? bpa_pkg::S_OUT : bpa_pkg::S_AORD;
            bpa_pkg::CMD_FREE:  state_nxt = free_bad ? bpa_pkg::S_OUT : bpa_pkg::S_FCHK;
            default:            state_nxt = bpa_pkg::S_OUT;
          endcase
        end
      end
      bpa_pkg::S_LAY: begin
        if (lay_full) state_nxt = bpa_pkg::S_OUT;
        else if (lay_fit) state_nxt = bpa_pkg::S_PUSH1;
      end
      bpa_pkg::S_AORD:  if (cnt_r <= sz_r) state_nxt = bpa_pkg::S_ASRCH;
      bpa_pkg::S_ASRCH: begin
        if (srch_out) state_nxt = bpa_pkg::S_OUT;
        else if (!head_empty) state_nxt = bpa_pkg::S_UNL0;
      end
      bpa_pkg::S_SPLIT: state_nxt = split_more ? bpa_pkg::S_PUSH1 : bpa_pkg::S_OUT;
      bpa_pkg::S_FCHK:  state_nxt = fchk_ok ? bpa_pkg::S_FLOOP : bpa_pkg::S_OUT;
      bpa_pkg::S_FLOOP: state_nxt = floop_go ? bpa_pkg::S_FBUD : bpa_pkg::S_FEND;
      bpa_pkg::S_FBUD:  state_nxt = bud_ok ? bpa_pkg::S_UNL0 : bpa_pkg::S_FEND;
      bpa_pkg::S_FMA:   state_nxt = bpa_pkg::S_FMB;
      bpa_pkg::S_FMB:   state_nxt = bpa_pkg::S_FLOOP;
      bpa_pkg::S_FEND:  state_nxt = bpa_pkg::S_PUSH1;
      bpa_pkg::S_FDONE: state_nxt = bpa_pkg::S_OUT;
      bpa_pkg::S_PUSH1: state_nxt = bpa_pkg::S_PUSH2;
      bpa_pkg::S_PUSH2: state_nxt = ret_r;
      bpa_pkg::S_UNL0:  state_nxt = bpa_pkg::S_UNL1;
      bpa_pkg::S_UNL1:  state_nxt = ret_r;
      bpa_pkg::S_OUT:   if (out_slot) state_nxt = bpa_pkg::S_IDLE;
      default:          state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ret_nxt      = ret_r;
    head_nxt     = head_r;
    free_nxt     = free_r;
    managed_nxt  = managed_r;
    ocnt_nxt     = ocnt_r;
    clr_nxt      = clr_r;
    cnt_nxt      = cnt_r;
    sz_nxt       = sz_r;
    handle_nxt   = handle_r;
    g_nxt        = g_r;
    ord_nxt      = ord_r;
    orig_nxt     = orig_r;
    pg_nxt       = pg_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    push_ord_nxt = push_ord_r;
    push_pg_nxt  = push_pg_r;
    push_h_nxt   = push_h_r;
    unl_ord_nxt  = unl_ord_r;
    unl_pg_nxt   = unl_pg_r;
    code_nxt     = code_r;
    idx_nxt      = idx_r;
    st_we = 1'b0; st_waddr = pg_r; st_wdata = '0; st_raddr = pg_r;
    nx_we = 1'b0; nx_waddr = push_pg_r; nx_wdata = '0;
    pv_we = 1'b0; pv_waddr = push_pg_r; pv_wdata = '0;
    case (state_r)
      bpa_pkg::S_CLR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        clr_nxt  = clr_r + PW'(1);
      end
      bpa_pkg::S_IDLE: begin
        st_raddr = in_page_index;
        code_nxt = bpa_pkg::RC_REJECT;
        idx_nxt  = '0;
        if (in_fire) begin
          case (in_command)
            bpa_pkg::CMD_INIT: begin
              if (!init_bad) begin
                managed_nxt = total_r;
                free_nxt    = '0;
                ocnt_nxt    = ocnt_init;
                g_nxt       = ocnt_init - OW'(1);
                handle_nxt  = '0;
                clr_nxt     = '0;
                ret_nxt     = bpa_pkg::S_LAY;
                for (int i = 0; i < MAX_ORDERS; i++) head_nxt[i] = NO_PAGE;
              end
            end
            bpa_pkg::CMD_ALLOC: begin
              cnt_nxt = in_page_count;
              sz_nxt  = CW'(1);
              ord_nxt = '0;
            end
            bpa_pkg::CMD_FREE: pg_nxt = in_page_index;
            default: ;
          endcase
        end
      end
      bpa_pkg::S_LAY: begin
        if (lay_full) begin
          code_nxt = bpa_pkg::RC_DONE;
        end else if (lay_fit) begin
          push_ord_nxt = g_r;
          push_pg_nxt  = handle_r[PW-1:0];
          handle_nxt   = handle_r + lay_sz;
          free_nxt     = free_r + lay_sz;
          ret_nxt      = bpa_pkg::S_LAY;
        end else begin
          g_nxt = g_r - OW'(1);
        end
      end
      bpa_pkg::S_AORD: begin
        if (cnt_r > sz_r) begin
          sz_nxt  = sz_r << 1;
          ord_nxt = ord_r + OW'(1);
        end else begin
          g_nxt = ord_r;
        end
      end
      bpa_pkg::S_ASRCH: begin
        if (srch_out) begin
          code_nxt = bpa_pkg::RC_NOBLK;
        end else if (head_empty) begin
          g_nxt = g_r + OW'(1);
        end else begin
          pg_nxt      = cur_head[PW-1:0];
          unl_ord_nxt = g_r;
          unl_pg_nxt  = cur_head[PW-1:0];
          ret_nxt     = bpa_pkg::S_SPLIT;
        end
      end
      bpa_pkg::S_SPLIT: begin
        st_we = 1'b1;
        if (split_more) begin
          // mark upper half free, push it one order down
          st_waddr     = upper;
          st_wdata     = SW'(0) - SW'(g_r);
          push_ord_nxt = g_r - OW'(1);
          push_pg_nxt  = upper;
          g_nxt        = g_r - OW'(1);
          ret_nxt      = bpa_pkg::S_SPLIT;
        end else begin
          st_waddr = pg_r;
          st_wdata = SW'(ord_r) + SW'(1);
          free_nxt = free_r - sz_r;
          code_nxt = bpa_pkg::RC_DONE;
          idx_nxt  = pg_r;
        end
      end
      bpa_pkg::S_FCHK: begin
        g_nxt    = st_mag - OW'(1);
        orig_nxt = st_mag - OW'(1);
      end
      bpa_pkg::S_FLOOP: begin
        if (aligned) begin
          a_nxt = pg_r; b_nxt = pg_r + bs_p; st_raddr = pg_r + bs_p;
        end else begin
          a_nxt = pg_r - bs_p; b_nxt = pg_r; st_raddr = pg_r - bs_p;
        end
      end
      bpa_pkg::S_FBUD: begin
        unl_ord_nxt = g_r;
        unl_pg_nxt  = (a_r == pg_r) ? b_r : a_r;
        ret_nxt     = bpa_pkg::S_FMA;
      end
      bpa_pkg::S_FMA: begin
        st_we    = 1'b1;
        st_waddr = a_r;
        st_wdata = SW'(g_r) + SW'(2);
      end
      bpa_pkg::S_FMB: begin
        st_we    = 1'b1;
        st_waddr = b_r;
        pg_nxt   = a_r;
        g_nxt    = g_r + OW'(1);
      end
      bpa_pkg::S_FEND: begin
        st_we        = 1'b1;
        st_waddr     = pg_r;
        st_wdata     = neg_g1;
        push_ord_nxt = g_r;
        push_pg_nxt  = pg_r;
        ret_nxt      = bpa_pkg::S_FDONE;
      end
      bpa_pkg::S_FDONE: begin
        free_nxt = free_r + (CW'(1) << orig_r);
        code_nxt = bpa_pkg::RC_DONE;
      end
      bpa_pkg::S_PUSH1: begin
        // link new front, then fix old front's back link
        push_h_nxt = head_r[push_ord_r[LW-1:0]];
        nx_we    = 1'b1;
        nx_wdata = head_r[push_ord_r[LW-1:0]];
        pv_we    = 1'b1;
        pv_wdata = NO_PAGE;
        head_nxt[push_ord_r[LW-1:0]] = CW'(push_pg_r);
      end
      bpa_pkg::S_PUSH2: begin
        pv_we    = (push_h_r < NO_PAGE);
        pv_waddr = push_h_r[PW-1:0];
        pv_wdata = CW'(push_pg_r);
      end
      bpa_pkg::S_UNL1: begin
        if (pv_rdata < NO_PAGE) begin
          nx_we    = 1'b1;
          nx_waddr = pv_rdata[PW-1:0];
          nx_wdata = nx_rdata;
        end else begin
          head_nxt[unl_ord_r[LW-1:0]] = nx_rdata;
        end
        pv_we    = (nx_rdata < NO_PAGE);
        pv_waddr = nx_rdata[PW-1:0];
        pv_wdata = pv_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_CLR;
      ret_r       <= bpa_pkg::S_IDLE;
      clr_r       <= '0;
      free_r      <= '0;
      managed_r   <= '0;
      ocnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ORDERS; i++) head_r[i] <= NO_PAGE;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      clr_r     <= clr_nxt;
      free_r    <= free_nxt;
      managed_r <= managed_nxt;
      ocnt_r    <= ocnt_nxt;
      head_r    <= head_nxt;
      if (state_r == bpa_pkg::S_OUT && out_slot) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    sz_r       <= sz_nxt;
    handle_r   <= handle_nxt;
    g_r        <= g_nxt;
    ord_r      <= ord_nxt;
    orig_r     <= orig_nxt;
    pg_r       <= pg_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    push_ord_r <= push_ord_nxt;
    push_pg_r  <= push_pg_nxt;
    push_h_r   <= push_h_nxt;
    unl_ord_r  <= unl_ord_nxt;
    unl_pg_r   <= unl_pg_nxt;
    code_r     <= code_nxt;
    idx_r      <= idx_nxt;
    if (state_r == bpa_pkg::S_OUT && out_slot) begin
      out_code_r <= code_r;
      out_idx_r  <= idx_r;
      out_free_r <= free_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_code = out_code_r;
  assign out_block_index = out_idx_r;
  assign out_free_count  = out_free_r;

endmodule

### test/tb_buddy_page_allocator_core.sv
// Self-checking testbench for the buddy page allocator core.
module tb_buddy_page_allocator_core;

  localparam int NPG      = bpa_pkg::MAX_PAGES_DEF;
  localparam int NORD     = bpa_pkg::MAX_ORDERS_DEF;
  localparam int LIMIT    = 1500000;
  localparam int LONG_OFF = 500;

  typedef struct {
    logic [1:0]  cmd;
    logic [10:0] cnt;
    logic [9:0]  idx;
  } req_t;

  typedef struct {
    logic [1:0]  code;
    logic [9:0]  blk;
    logic [10:0] fc;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = bpa_pkg::CMD_INIT;
  logic [10:0] in_page_count = '0;
  logic [9:0]  in_page_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_code;
  logic [9:0]  out_block_index;
  logic [10:0] out_free_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  buddy_page_allocator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_page_count(in_page_count), .in_page_index(in_page_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_code(out_result_code),
    .out_block_index(out_block_index), .out_free_count(out_free_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow allocator state
  int tp_shadow = 1024;
  int stat [NPG];
  int lhead [NORD];
  int lnext [NPG];
  int lprev [NPG];
  int shadow_free = 0;
  int orders = 0;
  int managed = 0;

  req_t pending_reqs[$];
  res_t queued_results[$];   // predicted, request not yet accepted
  res_t awaited_results[$];  // request accepted, result outstanding
  int   live_blocks[$];      // heads currently allocated, used to build valid frees

  int   errors = 0;
  int   n_acc = 0;
  int   n_res = 0;
  int   cycles = 0;

  function automatic int st_get(int pg);
    return (pg < NPG) ? stat[pg] : 0;
  endfunction

  function automatic void st_set(int pg, int v);
    if (pg < NPG) stat[pg] = v;
  endfunction

  function automatic void list_push(int ord, int pg);
    int h;
    if (ord >= NORD || pg >= NPG) return;
    h = lhead[ord];
    lnext[pg] = h;
    lprev[pg] = NPG;
    if (h < NPG) lprev[h] = pg;
    lhead[ord] = pg;
  endfunction

  function automatic void list_unlink(int ord, int pg);
    int p, n;
    if (ord >= NORD || pg >= NPG) return;
    p = lprev[pg];
    n = lnext[pg];
    if (p < NPG) lnext[p] = n;
    else lhead[ord] = n;
    if (n < NPG) lprev[n] = p;
  endfunction

  function automatic int lay_out();
    int cmp, cnt, handle, sz;
    cmp = 2;
    cnt = 1;
    handle = 0;
    if (tp_shadow == 0 || tp_shadow > NPG) return bpa_pkg::RC_REJECT;
    for (int i = 0; i < NPG; i++) stat[i] = 0;
    managed = tp_shadow;
    shadow_free = 0;
    while (cmp <= managed && cnt < NORD) begin
      cnt++;
      cmp = cmp << 1;
    end
    orders = cnt;
    for (int g = 0; g < NORD; g++) lhead[g] = NPG;
    for (int g = orders - 1; g >= 0; g--) begin
      sz = 1 << g;
      while (managed - shadow_free >= sz) begin
        list_push(g, handle);
        handle += sz;
        shadow_free += sz;
      end
      if (shadow_free == managed) break;
    end
    return bpa_pkg::RC_DONE;
  endfunction

  function automatic int take_block(int n, output int where);
    int ord, sz, g, pg, upper;
    ord = 0;
    sz = 1;
    where = 0;
    if (n == 0 || n > shadow_free) return bpa_pkg::RC_REJECT;
    while (n > sz) begin
      sz = sz << 1;
      ord++;
    end
    g = ord;
    while (g < orders && lhead[g] >= NPG) g++;
    if (g >= orders) return bpa_pkg::RC_NOBLK;
    pg = lhead[g];
    list_unlink(g, pg);
    while (g > ord) begin
      upper = pg + (1 << (g - 1));
      st_set(upper, -g);
      list_push(g - 1, upper);
      g--;
    end
    st_set(pg, ord + 1);
    shadow_free -= sz;
    where = pg;
    return bpa_pkg::RC_DONE;
  endfunction

  function automatic int give_back(int pg);
    int st, g, orig, bs, a, b, bud;
    if (pg >= managed) return bpa_pkg::RC_REJECT;
    st = st_get(pg);
    if (st <= 0 || st > orders) return bpa_pkg::RC_REJECT;
    g = st - 1;
    orig = g;
    while (g + 1 < orders) begin
      bs = 1 << g;
      if ((pg & ((bs << 1) - 1)) == 0) begin
        a = pg;
        b = pg + bs;
        bud = b;
        if (b + bs > managed) break;
      end else begin
        if (pg < bs) break;
        b = pg;
        a = pg - bs;
        bud = a;
      end
      if (st_get(bud) != -(g + 1)) break;
      list_unlink(g, bud);
      st_set(a, g + 2);
      st_set(b, 0);
      pg = a;
      g++;
    end
    st_set(pg, -(g + 1));
    list_push(g, pg);
    shadow_free += 1 << orig;
    return bpa_pkg::RC_DONE;
  endfunction

  // Predict one request's result, then queue the request and its result.
  function automatic void add_req(logic [1:0] cmd, logic [10:0] cnt, logic [9:0] idx);
    req_t r;
    res_t e;
    int code, where;
    where = 0;
    case (cmd)
      bpa_pkg::CMD_INIT: begin
        code = lay_out();
        if (code == bpa_pkg::RC_DONE) live_blocks.delete();
      end
      bpa_pkg::CMD_ALLOC: begin
        code = take_block(cnt, where);
        if (code == bpa_pkg::RC_DONE) live_blocks.push_back(where);
      end
      bpa_pkg::CMD_FREE: begin
        code = give_back(idx);
        if (code == bpa_pkg::RC_DONE)
          for (int i = live_blocks.size() - 1; i >= 0; i--)
            if (live_blocks[i] == idx) live_blocks.delete(i);
      end
      default: code = bpa_pkg::RC_REJECT;
    endcase
    if (code != bpa_pkg::RC_DONE) where = 0;
    r.cmd = cmd;
    r.cnt = cnt;
    r.idx = idx;
    e.code = code[1:0];
    e.blk = where[9:0];
    e.fc = shadow_free[10:0];
    pending_reqs.push_back(r);
    queued_results.push_back(e);
  endfunction

  function automatic void add_random();
    int r, sel;
    logic [10:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      add_req(bpa_pkg::CMD_INIT, 11'($urandom), 10'($urandom));
    end else if (r < 50) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) cnt = 11'($urandom_range(1, 8));
      else if (sel < 85) cnt = 11'($urandom_range(1, 64));
      else if (sel < 95) cnt = 11'($urandom_range(1, 1024));
      else if (sel < 98) cnt = 11'd0;
      else cnt = 11'($urandom_range(1025, 2047));
      add_req(bpa_pkg::CMD_ALLOC, cnt, 10'($urandom));
    end else if (r < 90) begin
      if (live_blocks.size() > 0 && $urandom_range(0, 9) < 8)
        add_req(bpa_pkg::CMD_FREE, 11'($urandom),
                10'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]));
      else
        add_req(bpa_pkg::CMD_FREE, 11'($urandom), 10'($urandom));
    end else begin
      // noise: undefined command, or a stray free
      if ($urandom_range(0, 1) == 0) add_req(2'd3, 11'($urandom), 10'($urandom));
      else add_req(bpa_pkg::CMD_FREE, 11'($urandom), 10'($urandom_range(0, 1023)));
    end
  endfunction

  task automatic cfg_write(int value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tp_shadow = value & 32'h7FF;
  endtask

  // Wait until every result is back, then let the sequencer settle.
  task automatic drain();
    while (pending_reqs.size() != 0 || queued_results.size() != 0 ||
           awaited_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Stimulus and phase control
  initial begin
    int phase_tp [8];
    phase_tp = '{1024, 1, 2, 3, 1000, 1023, 5, 0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: commands before init, the whole range, rejects and no-block
    add_req(bpa_pkg::CMD_ALLOC, 11'd1, 10'd0);
    add_req(bpa_pkg::CMD_FREE, 11'd0, 10'd0);
    add_req(2'd3, 11'd2047, 10'd1023);
    add_req(bpa_pkg::CMD_INIT, 11'd0, 10'd0);
    add_req(bpa_pkg::CMD_ALLOC, 11'd0, 10'd0);
    add_req(bpa_pkg::CMD_ALLOC, 11'd1, 10'd1023);
    add_req(bpa_pkg::CMD_ALLOC, 11'd1024, 10'd0);
    add_req(bpa_pkg::CMD_ALLOC, 11'd2047, 10'd0);
    add_req(bpa_pkg::CMD_FREE, 11'd0, 10'd0);
    add_req(bpa_pkg::CMD_FREE, 11'd0, 10'd0);
    add_req(bpa_pkg::CMD_ALLOC, 11'd1024, 10'd0);
    add_req(bpa_pkg::CMD_ALLOC, 11'd1, 10'd0);
    add_req(bpa_pkg::CMD_FREE, 11'd0, 10'd1023);
    add_req(bpa_pkg::CMD_FREE, 11'd0, 10'd0);
    add_req(bpa_pkg::CMD_ALLOC, 11'd3, 10'd0);
    add_req(bpa_pkg::CMD_ALLOC, 11'd513, 10'd0);
    add_req(bpa_pkg::CMD_FREE, 11'd0, 10'd0);
    drain();
    cfg_write(1000);
    add_req(bpa_pkg::CMD_INIT, 11'd0, 10'd0);
    add_req(bpa_pkg::CMD_ALLOC, 11'd1000, 10'd0);
    add_req(bpa_pkg::CMD_FREE, 11'd0, 10'd999);
    drain();
    cfg_write(1025);
    add_req(bpa_pkg::CMD_INIT, 11'd0, 10'd0);
    add_req(bpa_pkg::CMD_ALLOC, 11'd1, 10'd0);
    drain();
    cfg_write(2047);
    add_req(bpa_pkg::CMD_INIT, 11'd0, 10'd0);
    drain();

    // Random phases over a spread of region sizes
    for (int p = 0; p < 8; p++) begin
      cfg_write((p == 7) ? $urandom_range(1, 1024) : phase_tp[p]);
      add_req(bpa_pkg::CMD_INIT, 11'd0, 10'd0);
      for (int i = 0; i < 168; i++) add_random();
      drain();
    end
    cfg_write(0);
    add_req(bpa_pkg::CMD_INIT, 11'd0, 10'd0);
    add_req(bpa_pkg::CMD_ALLOC, 11'd1, 10'd0);
    drain();
    repeat (100) @(posedge clk);

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Request driver: hold each request until accepted, then wait a drawn gap.
  int gap = 0;
  int sent = 0;
  always @(negedge clk) begin
    logic nv;
    req_t r;
    nv = in_valid;
    if (in_valid && n_acc == sent) begin
      nv = 1'b0;
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
    end
    if (!nv && rst_n) begin
      if (gap > 0) begin
        gap--;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_command <= r.cmd;
        in_page_count <= r.cnt;
        in_page_index <= r.idx;
        nv = 1'b1;
        sent++;
      end
    end
    in_valid <= nv;
  end

  // Result receiver: drawn stall per result, one long hold-off to back up the input
  int stall = 0;
  int seen = 0;
  always @(negedge clk) begin
    if (n_res != seen) begin
      seen = n_res;
      stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
      if (n_res == 200) stall = LONG_OFF;
    end
    if (stall > 0) begin
      out_ready <= 1'b0;
      stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: move predictions on acceptance, check results in order
  always @(posedge clk) begin
    res_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t timeout", $time);
      $display("Regression FAIL");
      $finish;
    end
    if (in_valid && in_ready) begin
      awaited_results.push_back(queued_results.pop_front());
      n_acc++;
    end
    if (out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual code %0d blk %0d fc %0d",
                 $time, out_result_code, out_block_index, out_free_count);
        errors++;
      end else begin
        e = awaited_results.pop_front();
        if (out_result_code !== e.code) begin
          $display("%0t result_code: expected %0d actual %0d", $time, e.code, out_result_code);
          errors++;
        end
        if (out_block_index !== e.blk) begin
          $display("%0t block_index: expected %0d actual %0d", $time, e.blk, out_block_index);
          errors++;
        end
        if (out_free_count !== e.fc) begin
          $display("%0t free_count: expected %0d actual %0d", $time, e.fc, out_free_count);
          errors++;
        end
      end
      n_res++;
    end
  end

endmodule

### files.f
design/bpa_pkg.sv
design/bpa_ram.sv
design/buddy_page_allocator_core.sv
test/tb_buddy_page_allocator_core.sv
